@@ src/frpm_pkg.sv @@
// Package for the frame rate pacer and monitor: widths, register indexes,
// the beat struct between the state stage and the percentage pipeline,
// and the constants of the busy-percentage division. Depends on nothing.
`default_nettype none
package frpm_pkg;

  localparam int unsigned MS_PER_SECOND = 1000;
  localparam int unsigned PCT_SCALE     = 100;
  localparam int unsigned PCT_MAX       = 65535;

  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned SLIP_W   = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PERIOD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SLIP_THRESHOLD = CFG_IDX_W'(1);

  localparam logic ACT_FRAME   = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(33);
  localparam logic [SLIP_W-1:0]   SLIP_RESET   = SLIP_W'(3);

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 80;

  // Largest busy sum whose percentage stays below saturation.
  localparam longint SAT_SUM = (longint'(PCT_MAX) * MS_PER_SECOND) / PCT_SCALE;
  // Width of sum*100 for a sum at or below SAT_SUM.
  localparam int unsigned SCALED_W  = $clog2(longint'(PCT_MAX) * MS_PER_SECOND + 1);
  localparam int unsigned DIV_SHIFT = SCALED_W + $clog2(MS_PER_SECOND + 1);
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1 - $clog2(MS_PER_SECOND);
  localparam int unsigned PROD_W    = SCALED_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << DIV_SHIFT) + MS_PER_SECOND - 1) / MS_PER_SECOND);

  typedef struct packed {
    logic [TIME_W-1:0]   frame_delta;
    logic [PERIOD_W-1:0] wait_ms;
    logic [COUNT_W-1:0]  fps;
    logic [TIME_W-1:0]   busy_sum;
    logic                report_ready;
  } frpm_beat_t;

  typedef struct packed {
    logic [TIME_W-1:0]   frame_delta;
    logic [PERIOD_W-1:0] wait_ms;
    logic [COUNT_W-1:0]  fps;
    logic                report_ready;
    logic                sat;
    logic                zero;
  } frpm_pipe_t;

endpackage
`default_nettype wire

@@ src/frpm_state.sv @@
// State stage of the frame rate pacer: configuration registers, frame and
// report targets, busy sum and frame counter, and the first result register.
// Depends on frpm_pkg.
`default_nettype none
module frpm_state (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [frpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [frpm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  input  wire logic                              adv,
  input  wire logic                              action,
  input  wire logic [frpm_pkg::TIME_W-1:0]       now_ms,
  input  wire logic                              clear_dirty,
  output logic                                   s1_valid,
  output frpm_pkg::frpm_beat_t                   s1_beat
);

  logic [frpm_pkg::PERIOD_W-1:0] period_r;
  logic [frpm_pkg::SLIP_W-1:0]   slip_r;
  logic [frpm_pkg::TIME_W-1:0]   frame_target_r, frame_target_nxt;
  logic [frpm_pkg::TIME_W-1:0]   report_target_r, report_target_nxt;
  logic [frpm_pkg::TIME_W-1:0]   busy_sum_r, busy_sum_nxt;
  logic [frpm_pkg::TIME_W-1:0]   busy_raw_r, busy_raw_nxt;
  logic [frpm_pkg::COUNT_W-1:0]  frame_cnt_r, frame_cnt_nxt;
  logic [frpm_pkg::COUNT_W-1:0]  fps_r, fps_nxt;
  logic                          dirty_r, dirty_nxt;
  logic                          s1_valid_r, s1_valid_nxt;
  frpm_pkg::frpm_beat_t          beat_r, beat_nxt;

  logic [frpm_pkg::TIME_W-1:0]   delta, report_delta, sum_add;
  logic [frpm_pkg::COUNT_W-1:0]  cnt_inc;
  logic [frpm_pkg::PERIOD_W+frpm_pkg::SLIP_W-1:0] slip_lim;
  logic                          accept, report_due, dirty_now;
  logic [frpm_pkg::PERIOD_W-1:0] wait_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= frpm_pkg::PERIOD_RESET;
      slip_r   <= frpm_pkg::SLIP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        frpm_pkg::REG_TARGET_PERIOD:  period_r <= cfg_data[frpm_pkg::PERIOD_W-1:0];
        frpm_pkg::REG_SLIP_THRESHOLD: slip_r   <= cfg_data[frpm_pkg::SLIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    accept       = in_valid && adv;
    delta        = now_ms - frame_target_r;
    report_delta = now_ms - report_target_r;
    sum_add      = busy_sum_r + delta;
    cnt_inc      = (frame_cnt_r == {frpm_pkg::COUNT_W{1'b1}}) ? frame_cnt_r
                                                              : frame_cnt_r + 1'b1;
    slip_lim     = (frpm_pkg::PERIOD_W + frpm_pkg::SLIP_W)'(slip_r) *
                   (frpm_pkg::PERIOD_W + frpm_pkg::SLIP_W)'(period_r);
    report_due   = report_delta >= frpm_pkg::TIME_W'(frpm_pkg::MS_PER_SECOND);
    wait_val     = (delta < frpm_pkg::TIME_W'(period_r)) ?
                   period_r - delta[frpm_pkg::PERIOD_W-1:0] : '0;

    frame_target_nxt  = frame_target_r;
    report_target_nxt = report_target_r;
    busy_sum_nxt      = busy_sum_r;
    busy_raw_nxt      = busy_raw_r;
    frame_cnt_nxt     = frame_cnt_r;
    fps_nxt           = fps_r;
    dirty_nxt         = dirty_r;
    dirty_now         = dirty_r;
    beat_nxt          = beat_r;
    s1_valid_nxt      = adv ? in_valid : s1_valid_r;

    if (accept) begin
      if (action == frpm_pkg::ACT_RESTART) begin
        frame_target_nxt  = now_ms;
        report_target_nxt = now_ms;
        busy_sum_nxt      = '0;
        busy_raw_nxt      = '0;
        frame_cnt_nxt     = '0;
        fps_nxt           = '0;
        dirty_nxt         = 1'b0;
        beat_nxt          = '0;
      end else begin
        busy_sum_nxt  = sum_add;
        frame_cnt_nxt = cnt_inc;
        if (report_due) begin
          busy_raw_nxt      = sum_add;
          busy_sum_nxt      = '0;
          fps_nxt           = cnt_inc;
          frame_cnt_nxt     = '0;
          report_target_nxt = report_target_r + frpm_pkg::TIME_W'(frpm_pkg::MS_PER_SECOND);
          dirty_now         = 1'b1;
        end
        if (delta > frpm_pkg::TIME_W'(slip_lim)) begin
          frame_target_nxt = now_ms + frpm_pkg::TIME_W'(period_r);
        end else begin
          frame_target_nxt = frame_target_r + frpm_pkg::TIME_W'(period_r);
        end
        dirty_nxt             = dirty_now && !clear_dirty;
        beat_nxt.frame_delta  = delta;
        beat_nxt.wait_ms      = wait_val;
        beat_nxt.fps          = fps_nxt;
        beat_nxt.busy_sum     = busy_raw_nxt;
        beat_nxt.report_ready = dirty_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_target_r  <= '0;
      report_target_r <= '0;
      busy_sum_r      <= '0;
      busy_raw_r      <= '0;
      frame_cnt_r     <= '0;
      fps_r           <= '0;
      dirty_r         <= 1'b0;
      s1_valid_r      <= 1'b0;
    end else begin
      frame_target_r  <= frame_target_nxt;
      report_target_r <= report_target_nxt;
      busy_sum_r      <= busy_sum_nxt;
      busy_raw_r      <= busy_raw_nxt;
      frame_cnt_r     <= frame_cnt_nxt;
      fps_r           <= fps_nxt;
      dirty_r         <= dirty_nxt;
      s1_valid_r      <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_beat  = beat_r;

endmodule
`default_nettype wire

@@ src/frpm_pct.sv @@
// Busy-percentage pipeline of the frame rate pacer: scales the latched busy
// sum, divides it by one second through a reciprocal product and drives the
// output register. Depends on frpm_pkg.
`default_nettype none
module frpm_pct (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                s1_valid,
  input  wire frpm_pkg::frpm_beat_t                s1_beat,
  output logic                                     s1_adv,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [frpm_pkg::OUT_DATA_W-1:0]          out_tdata
);

  logic                              s2_v_r, s3_v_r, out_v_r;
  logic                              s2_en, s3_en, out_en;
  frpm_pkg::frpm_pipe_t              s2_r, s2_nxt, s3_r;
  logic [frpm_pkg::SCALED_W-1:0]     scaled_r, scaled_nxt;
  logic [frpm_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic [frpm_pkg::COUNT_W-1:0]      pct;
  logic [frpm_pkg::OUT_DATA_W-1:0]   tdata_r, tdata_nxt;

  always_comb begin
    out_en = !out_v_r || out_tready;
    s3_en  = !s3_v_r || out_en;
    s2_en  = !s2_v_r || s3_en;
    s1_adv = !s1_valid || s2_en;

    s2_nxt.frame_delta  = s1_beat.frame_delta;
    s2_nxt.wait_ms      = s1_beat.wait_ms;
    s2_nxt.fps          = s1_beat.fps;
    s2_nxt.report_ready = s1_beat.report_ready;
    s2_nxt.sat          = s1_beat.busy_sum > frpm_pkg::TIME_W'(frpm_pkg::SAT_SUM);
    s2_nxt.zero         = s1_beat.busy_sum == '0;
    scaled_nxt = frpm_pkg::SCALED_W'(s1_beat.busy_sum) *
                 frpm_pkg::SCALED_W'(frpm_pkg::PCT_SCALE) - 1'b1;

    prod_nxt = frpm_pkg::PROD_W'(scaled_r) * frpm_pkg::PROD_W'(frpm_pkg::RECIP);

    if (s3_r.sat) begin
      pct = {frpm_pkg::COUNT_W{1'b1}};
    end else if (s3_r.zero) begin
      pct = '0;
    end else begin
      pct = frpm_pkg::COUNT_W'(prod_r >> frpm_pkg::DIV_SHIFT) + 1'b1;
    end
    tdata_nxt = {5'b0, s3_r.report_ready, pct, s3_r.fps, s3_r.wait_ms, s3_r.frame_delta};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_v_r <= s1_valid;
      end
      if (s3_en) begin
        s3_v_r <= s2_v_r;
      end
      if (out_en) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_r     <= s2_nxt;
      scaled_r <= scaled_nxt;
    end
    if (s3_en) begin
      s3_r   <= s2_r;
      prod_r <= prod_nxt;
    end
    if (out_en) begin
      tdata_r <= tdata_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = tdata_r;

endmodule
`default_nettype wire

@@ src/frame_rate_pacer_monitor_core.sv @@
// Top level of the frame rate pacer and monitor: joins the state stage and
// the busy-percentage pipeline. Depends on frpm_pkg, frpm_state and frpm_pct.
//
// The block takes one beat per clock cycle unless back-pressure from the
// output stalls it; the frame and report targets, the busy sum and the
// counters are updated in the single cycle in which a beat is accepted, so a
// following beat sees them at once. A result reaches the output register
// through four registers: the state stage, the scaling stage, the reciprocal
// multiplier and the output register. Beats are never dropped; any free
// stage lets a new input beat in while the output waits. Configuration
// writes are always accepted and act at once.
`default_nettype none
module frame_rate_pacer_monitor_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [frpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [frpm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // now_ms [31:0], clear_dirty [32], zero fill [39:33]
  input  wire logic [frpm_pkg::IN_DATA_W-1:0]    in_tdata,
  // action [0]
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // frame_delta [31:0], wait_ms [41:32], frames_per_second [57:42],
  // busy_percent [73:58], report_ready [74], zero fill [79:75]
  output logic [frpm_pkg::OUT_DATA_W-1:0]        out_tdata
);

  logic                 s1_valid, s1_adv;
  frpm_pkg::frpm_beat_t s1_beat;

  assign cfg_ready = 1'b1;
  assign in_tready = s1_adv;

  frpm_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_tvalid),
    .adv         (s1_adv),
    .action      (in_tuser),
    .now_ms      (in_tdata[frpm_pkg::TIME_W-1:0]),
    .clear_dirty (in_tdata[frpm_pkg::TIME_W]),
    .s1_valid    (s1_valid),
    .s1_beat     (s1_beat)
  );

  frpm_pct u_pct (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_beat    (s1_beat),
    .s1_adv     (s1_adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef NO_ASSERTIONS
  a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == frpm_pkg::ACT_RESTART |=>
      s1_valid && s1_beat.frame_delta == '0 && !s1_beat.report_ready)
    else $error("restart beat did not give a cleared result");

  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && s1_beat.wait_ms != '0 |->
      s1_beat.frame_delta[frpm_pkg::TIME_W-1:frpm_pkg::PERIOD_W] == '0)
    else $error("nonzero wait with a delta beyond any period");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the output register is empty");
`endif

endmodule
`default_nettype wire
